// File: rtl/core/ctf_pkg.sv
// ----------------------------------------------------------------------------
// ctf_pkg
// Shared types, constants and helper functions of the tilt filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ctf_pkg;

    localparam int unsigned CTF_CORDIC_STEPS = 16;
    localparam int unsigned CTF_ATAN_LEN     = 24;
    localparam int unsigned CTF_QUEUE_DEPTH  = 2;
    localparam int unsigned CTF_PADDR_W      = 4;

    localparam int unsigned CTF_SAMPLE_W = 16;
    localparam int unsigned CTF_ANGLE_W  = 32;
    localparam int unsigned CTF_TILT_W   = 26;
    localparam int unsigned CTF_CORDIC_W = 33;
    localparam int unsigned CTF_ATAN_W   = 22;
    localparam int unsigned CTF_MUL_A_W  = 18;
    localparam int unsigned CTF_PROD_W   = 50;
    localparam int unsigned CTF_ACC_W    = 51;
    localparam int unsigned CTF_MAG_W    = 17;

    localparam logic [16:0] CTF_ONE_Q16 = 17'd65536;
    localparam logic signed [CTF_TILT_W-1:0] CTF_DEG180 = 26'sd11796480;

    localparam logic [15:0] CTF_DT_RESET     = 16'd655;
    localparam logic [16:0] CTF_WEIGHT_RESET = 17'd64225;
    localparam logic [16:0] CTF_GATE_LO_RESET = 17'd2048;
    localparam logic [16:0] CTF_GATE_HI_RESET = 17'd8192;

    typedef enum logic [1:0] {
        CTF_REG_DT_STEP     = 2'd0,
        CTF_REG_GYRO_WEIGHT = 2'd1,
        CTF_REG_GATE_LOW    = 2'd2,
        CTF_REG_GATE_HIGH   = 2'd3
    } t_ctf_reg;

    typedef struct packed {
        logic [15:0] dt_step;
        logic [16:0] gyro_weight;
        logic [16:0] gate_low;
        logic [16:0] gate_high;
    } t_ctf_cfg;

    typedef struct packed {
        logic signed [CTF_SAMPLE_W-1:0] accel_x;
        logic signed [CTF_SAMPLE_W-1:0] accel_y;
        logic signed [CTF_SAMPLE_W-1:0] accel_z;
        logic signed [CTF_SAMPLE_W-1:0] gyro_x;
        logic signed [CTF_SAMPLE_W-1:0] gyro_y;
        logic                           applied;
    } t_ctf_item;

    function automatic logic [CTF_ATAN_W-1:0] ctf_atan(input logic [4:0] idx);
        logic [CTF_ATAN_W-1:0] val;
        case (idx)
            5'd0:    val = 22'd2949120;
            5'd1:    val = 22'd1740967;
            5'd2:    val = 22'd919879;
            5'd3:    val = 22'd466945;
            5'd4:    val = 22'd234379;
            5'd5:    val = 22'd117304;
            5'd6:    val = 22'd58666;
            5'd7:    val = 22'd29335;
            5'd8:    val = 22'd14668;
            5'd9:    val = 22'd7334;
            5'd10:   val = 22'd3667;
            5'd11:   val = 22'd1833;
            5'd12:   val = 22'd917;
            5'd13:   val = 22'd458;
            5'd14:   val = 22'd229;
            5'd15:   val = 22'd115;
            5'd16:   val = 22'd57;
            5'd17:   val = 22'd29;
            5'd18:   val = 22'd14;
            5'd19:   val = 22'd7;
            5'd20:   val = 22'd4;
            5'd21:   val = 22'd2;
            5'd22:   val = 22'd1;
            default: val = 22'd0;
        endcase
        return val;
    endfunction

    function automatic logic signed [CTF_ANGLE_W-1:0] ctf_sat32(
        input logic signed [CTF_ACC_W-1:0] v
    );
        logic [CTF_ACC_W-CTF_ANGLE_W:0] top;
        logic signed [CTF_ANGLE_W-1:0]  res;
        top = v[CTF_ACC_W-1:CTF_ANGLE_W-1];
        if ((&top) || !(|top)) begin
            res = v[CTF_ANGLE_W-1:0];
        end else if (v[CTF_ACC_W-1]) begin
            res = {1'b1, {(CTF_ANGLE_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(CTF_ANGLE_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ctf_if.sv
// ----------------------------------------------------------------------------
// ctf_if
// Sample and result channels of the tilt filter, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctf_in_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    output gyro_x, output gyro_y, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    input gyro_x, input gyro_y, output ready);
endinterface

interface ctf_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] pitch_out;
    logic signed [31:0] roll_out;
    logic        accel_applied;

    modport source (output valid, output pitch_out, output roll_out,
                    output accel_applied, input ready);
    modport sink   (input valid, input pitch_out, input roll_out,
                    input accel_applied, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ctf_front.sv
// ----------------------------------------------------------------------------
// ctf_front
// Accepts a sample beat, evaluates the accelerometer magnitude gate and
// hands the classified sample to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ctf_front (
    ctf_in_if.sink              i_smp,
    input  ctf_pkg::t_ctf_cfg   i_cfg,
    input  logic                i_full,
    output logic                o_push,
    output ctf_pkg::t_ctf_item  o_item
);

    logic [ctf_pkg::CTF_MAG_W-1:0] abs_x;
    logic [ctf_pkg::CTF_MAG_W-1:0] abs_y;
    logic [ctf_pkg::CTF_MAG_W-1:0] abs_z;
    logic [ctf_pkg::CTF_MAG_W-1:0] mag;

    always_comb begin
        abs_x = i_smp.accel_x[15] ? (17'd0 - 17'(i_smp.accel_x)) : 17'(i_smp.accel_x);
        abs_y = i_smp.accel_y[15] ? (17'd0 - 17'(i_smp.accel_y)) : 17'(i_smp.accel_y);
        abs_z = i_smp.accel_z[15] ? (17'd0 - 17'(i_smp.accel_z)) : 17'(i_smp.accel_z);
        mag   = abs_x + abs_y + abs_z;
    end

    assign i_smp.ready = !i_full;
    assign o_push      = i_smp.valid && !i_full;

    always_comb begin
        o_item.accel_x = i_smp.accel_x;
        o_item.accel_y = i_smp.accel_y;
        o_item.accel_z = i_smp.accel_z;
        o_item.gyro_x  = i_smp.gyro_x;
        o_item.gyro_y  = i_smp.gyro_y;
        o_item.applied = (mag > i_cfg.gate_low) && (mag < i_cfg.gate_high);
    end

endmodule

`default_nettype wire

// File: rtl/core/ctf_fifo.sv
// ----------------------------------------------------------------------------
// ctf_fifo
// Short queue of classified samples between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ctf_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ctf_pkg::t_ctf_item  i_item,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output ctf_pkg::t_ctf_item  o_item
);

    localparam int unsigned DEPTH = ctf_pkg::CTF_QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ctf_pkg::t_ctf_item r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ctf_cordic.sv
// ----------------------------------------------------------------------------
// ctf_cordic
// Iterative vectoring CORDIC that returns atan2(y, x) in Q16 degrees,
// one micro-rotation per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module ctf_cordic #(
    parameter int unsigned STEPS = ctf_pkg::CTF_CORDIC_STEPS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [ctf_pkg::CTF_SAMPLE_W-1:0] i_y,
    input  logic signed [ctf_pkg::CTF_SAMPLE_W-1:0] i_x,
    output logic                                   o_busy,
    output logic signed [ctf_pkg::CTF_TILT_W-1:0]   o_angle
);

    localparam int unsigned RUN   = (STEPS > ctf_pkg::CTF_ATAN_LEN) ?
                                    ctf_pkg::CTF_ATAN_LEN : STEPS;
    localparam int unsigned CNT_W = (RUN > 1) ? $clog2(RUN) : 1;
    localparam int unsigned CW    = ctf_pkg::CTF_CORDIC_W;
    localparam int unsigned TW    = ctf_pkg::CTF_TILT_W;

    logic signed [CW-1:0] r_x, n_x;
    logic signed [CW-1:0] r_y, n_y;
    logic signed [TW-1:0] r_z, n_z;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_zero, n_zero;

    logic signed [16:0]   x_ext;
    logic signed [16:0]   y_ext;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [TW-1:0] step;

    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_zero = r_zero;
        x_ext  = 17'(i_x);
        y_ext  = 17'(i_y);
        xs     = r_x >>> r_cnt;
        ys     = r_y >>> r_cnt;
        step   = signed'({{(TW - ctf_pkg::CTF_ATAN_W){1'b0}}, ctf_pkg::ctf_atan(5'(r_cnt))});
        if (i_start) begin
            n_zero = (i_x == '0) && (i_y == '0);
            if (i_x[ctf_pkg::CTF_SAMPLE_W-1]) begin
                x_ext = -x_ext;
                y_ext = -y_ext;
                n_z   = i_y[ctf_pkg::CTF_SAMPLE_W-1] ? -ctf_pkg::CTF_DEG180
                                                     : ctf_pkg::CTF_DEG180;
            end else begin
                n_z = '0;
            end
            n_x    = CW'(x_ext) <<< 14;
            n_y    = CW'(y_ext) <<< 14;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!r_y[CW-1]) begin
                n_x = r_x + ys;
                n_y = r_y - xs;
                n_z = r_z + step;
            end else begin
                n_x = r_x - ys;
                n_y = r_y + xs;
                n_z = r_z - step;
            end
            if (r_cnt == CNT_W'(RUN - 1)) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_zero <= n_zero;
    end

    assign o_busy  = r_busy;
    assign o_angle = r_zero ? '0 : r_z;

endmodule

`default_nettype wire

// File: rtl/core/ctf_back.sv
// ----------------------------------------------------------------------------
// ctf_back
// Back end: integrates the gyro rates and, for gated samples, runs the two
// tilt CORDICs and blends the angles through one shared multiplier, then registers the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ctf_back #(
    parameter int unsigned CORDIC_STEPS = ctf_pkg::CTF_CORDIC_STEPS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ctf_pkg::t_ctf_cfg   i_cfg,
    input  logic                i_valid,
    input  ctf_pkg::t_ctf_item  i_item,
    output logic                o_pop,
    ctf_out_if.source           o_res
);

    localparam int unsigned AW = ctf_pkg::CTF_ANGLE_W;
    localparam int unsigned PW = ctf_pkg::CTF_PROD_W;
    localparam int unsigned SW = ctf_pkg::CTF_ACC_W;
    localparam int unsigned MW = ctf_pkg::CTF_MUL_A_W;

    typedef enum logic [3:0] {
        S_IDLE, S_GX, S_GY, S_GEND, S_WAIT, S_BP2, S_BP3, S_BR2, S_BR3, S_OUT
    } t_state;

    t_state                 r_state, n_state;
    logic signed [15:0]     r_gx, n_gx;
    logic signed [15:0]     r_gy, n_gy;
    logic                   r_applied, n_applied;
    logic signed [AW-1:0]   r_pitch, n_pitch;
    logic signed [AW-1:0]   r_roll, n_roll;
    logic signed [PW-1:0]   r_prod, n_prod;
    logic signed [PW-1:0]   r_acc, n_acc;
    logic                   r_ovalid, n_ovalid;
    logic signed [AW-1:0]   r_opitch, n_opitch;
    logic signed [AW-1:0]   r_oroll, n_oroll;
    logic                   r_oapplied, n_oapplied;

    logic [16:0]            w_gyro;
    logic [16:0]            w_accel;
    logic signed [MW-1:0]   mul_a;
    logic signed [AW-1:0]   mul_b;
    logic signed [SW-1:0]   gyro_sum;
    logic signed [SW-1:0]   blend_sum;
    logic                   cordic_start;
    logic                   busy_p;
    logic                   busy_r;
    logic signed [ctf_pkg::CTF_TILT_W-1:0] tilt_p;
    logic signed [ctf_pkg::CTF_TILT_W-1:0] tilt_r;

    assign o_pop        = (r_state == S_IDLE) && i_valid;
    assign cordic_start = o_pop && i_item.applied;

    ctf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_y     (i_item.accel_y),
        .i_x     (i_item.accel_z),
        .o_busy  (busy_p),
        .o_angle (tilt_p)
    );

    ctf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_y     (i_item.accel_x),
        .i_x     (i_item.accel_z),
        .o_busy  (busy_r),
        .o_angle (tilt_r)
    );

    always_comb begin
        w_gyro  = (i_cfg.gyro_weight > ctf_pkg::CTF_ONE_Q16) ? ctf_pkg::CTF_ONE_Q16
                                                             : i_cfg.gyro_weight;
        w_accel = ctf_pkg::CTF_ONE_Q16 - w_gyro;
    end

    always_comb begin
        case (r_state)
            S_GX: begin
                mul_a = signed'({2'b00, i_cfg.dt_step});
                mul_b = AW'(r_gx);
            end
            S_GY: begin
                mul_a = signed'({2'b00, i_cfg.dt_step});
                mul_b = AW'(r_gy);
            end
            S_WAIT: begin
                mul_a = signed'({1'b0, w_gyro});
                mul_b = r_pitch;
            end
            S_BP2: begin
                mul_a = signed'({1'b0, w_accel});
                mul_b = AW'(tilt_p);
            end
            S_BP3: begin
                mul_a = signed'({1'b0, w_gyro});
                mul_b = r_roll;
            end
            S_BR2: begin
                mul_a = signed'({1'b0, w_accel});
                mul_b = AW'(tilt_r);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_gx       = r_gx;
        n_gy       = r_gy;
        n_applied  = r_applied;
        n_pitch    = r_pitch;
        n_roll     = r_roll;
        n_acc      = r_acc;
        n_prod     = PW'(mul_a) * PW'(mul_b);
        n_ovalid   = r_ovalid && !o_res.ready;
        n_opitch   = r_opitch;
        n_oroll    = r_oroll;
        n_oapplied = r_oapplied;
        gyro_sum   = '0;
        blend_sum  = (SW'(r_acc) + SW'(r_prod)) >>> 16;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_gx      = i_item.gyro_x;
                    n_gy      = i_item.gyro_y;
                    n_applied = i_item.applied;
                    n_state   = S_GX;
                end
            end
            S_GX: begin
                n_state = S_GY;
            end
            S_GY: begin
                gyro_sum = SW'(r_pitch) + SW'(r_prod >>> 4);
                n_pitch  = ctf_pkg::ctf_sat32(gyro_sum);
                n_state  = S_GEND;
            end
            S_GEND: begin
                gyro_sum = SW'(r_roll) - SW'(r_prod >>> 4);
                n_roll   = ctf_pkg::ctf_sat32(gyro_sum);
                n_state  = r_applied ? S_WAIT : S_OUT;
            end
            S_WAIT: begin
                if (!busy_p && !busy_r) begin
                    n_state = S_BP2;
                end
            end
            S_BP2: begin
                n_acc   = r_prod;
                n_state = S_BP3;
            end
            S_BP3: begin
                n_pitch = ctf_pkg::ctf_sat32(blend_sum);
                n_state = S_BR2;
            end
            S_BR2: begin
                n_acc   = r_prod;
                n_state = S_BR3;
            end
            S_BR3: begin
                n_roll  = ctf_pkg::ctf_sat32(blend_sum);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid   = 1'b1;
                    n_opitch   = r_pitch;
                    n_oroll    = r_roll;
                    n_oapplied = r_applied;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pitch  <= '0;
            r_roll   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pitch  <= n_pitch;
            r_roll   <= n_roll;
            r_ovalid <= n_ovalid;
        end
        r_gx       <= n_gx;
        r_gy       <= n_gy;
        r_applied  <= n_applied;
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_opitch   <= n_opitch;
        r_oroll    <= n_oroll;
        r_oapplied <= n_oapplied;
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.pitch_out     = r_opitch;
    assign o_res.roll_out      = r_oroll;
    assign o_res.accel_applied = r_oapplied;

endmodule

`default_nettype wire

// File: rtl/core/complementary_tilt_filter_unit.sv
// ----------------------------------------------------------------------------
// complementary_tilt_filter_unit
// Complementary pitch/roll filter with APB register port.
// ----------------------------------------------------------------------------
// Each sample beat updates pitch and roll (Q16 degrees) from the gyro rates
// and, when the accelerometer magnitude lies inside the gate, blends both
// angles with CORDIC atan2 tilt angles; one result beat follows per sample.
// Without the blend the back end passes S_GX, S_GY, S_GEND and S_OUT on a
// sample; with the blend it adds S_WAIT and S_BP2 to S_BR3 before S_OUT.
// The added time is set by the CORDIC iterations (two units working in
// parallel) followed by the blend products on one shared 18 x 32
// multiplier. A stalled result beat holds the back end until it is taken.
// A two-entry queue lets the input take new samples while the back end is
// busy.
// ----------------------------------------------------------------------------
`default_nettype none

module complementary_tilt_filter_unit #(
    parameter int unsigned CORDIC_STEPS = ctf_pkg::CTF_CORDIC_STEPS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ctf_in_if.sink                            i_smp,
    ctf_out_if.source                         o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ctf_pkg::CTF_PADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    ctf_pkg::t_ctf_cfg  r_cfg;
    ctf_pkg::t_ctf_reg  reg_sel;
    ctf_pkg::t_ctf_item push_item;
    ctf_pkg::t_ctf_item queue_item;
    logic               push;
    logic               pop;
    logic               full;
    logic               queue_valid;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_sel = ctf_pkg::t_ctf_reg'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dt_step     <= ctf_pkg::CTF_DT_RESET;
            r_cfg.gyro_weight <= ctf_pkg::CTF_WEIGHT_RESET;
            r_cfg.gate_low    <= ctf_pkg::CTF_GATE_LO_RESET;
            r_cfg.gate_high   <= ctf_pkg::CTF_GATE_HI_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                ctf_pkg::CTF_REG_DT_STEP:     r_cfg.dt_step     <= pwdata[15:0];
                ctf_pkg::CTF_REG_GYRO_WEIGHT: r_cfg.gyro_weight <= pwdata[16:0];
                ctf_pkg::CTF_REG_GATE_LOW:    r_cfg.gate_low    <= pwdata[16:0];
                ctf_pkg::CTF_REG_GATE_HIGH:   r_cfg.gate_high   <= pwdata[16:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            ctf_pkg::CTF_REG_DT_STEP:     prdata = {16'd0, r_cfg.dt_step};
            ctf_pkg::CTF_REG_GYRO_WEIGHT: prdata = {15'd0, r_cfg.gyro_weight};
            ctf_pkg::CTF_REG_GATE_LOW:    prdata = {15'd0, r_cfg.gate_low};
            ctf_pkg::CTF_REG_GATE_HIGH:   prdata = {15'd0, r_cfg.gate_high};
            default:                      prdata = '0;
        endcase
    end

    ctf_front u_front (
        .i_smp  (i_smp),
        .i_cfg  (r_cfg),
        .i_full (full),
        .o_push (push),
        .o_item (push_item)
    );

    ctf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (queue_valid),
        .o_item  (queue_item)
    );

    ctf_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (queue_valid),
        .i_item  (queue_item),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// File: rtl/core/ctf_checker.sv
// ----------------------------------------------------------------------------
// ctf_checker
// Port-level checks of the tilt filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ctf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_pitch,
    input logic [31:0] i_roll,
    input logic        i_applied
);

    logic [2:0] r_inflight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 3'((i_in_valid && i_in_ready) ? 1 : 0)
                                     - 3'((i_out_valid && i_out_ready) ? 1 : 0);
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_pitch) && $stable(i_roll) && $stable(i_applied))
        else $error("result payload changed while stalled");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_inflight != 3'd0)
        else $error("result beat without a pending sample");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd4)
        else $error("more samples in flight than the design can hold");

endmodule

bind complementary_tilt_filter_unit ctf_checker u_ctf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_pitch     (o_res.pitch_out),
    .i_roll      (o_res.roll_out),
    .i_applied   (o_res.accel_applied)
);

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the complementary pitch/roll tilt filter.
// ----------------------------------------------------------------------------
// A driver feeds IMU sample beats from a queue of pending samples, and a
// predictor of the filter state (gyro integration, magnitude gate, CORDIC
// atan2 and blend) computes the result expected from each accepted beat.
// A monitor compares every result beat field by field with the oldest
// expectation. The register port is reprogrammed between phases of directed
// and random samples while both sides idle at random rates.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int  CORDIC_N      = ctf_pkg::CTF_CORDIC_STEPS;
    localparam int  SETTLE_CYCLES = 48;
    localparam int  STALL_LIMIT   = 3000;
    localparam longint DEG180_Q16 = 64'sd11796480;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
    } t_imu_sample;

    typedef struct packed {
        logic signed [31:0] pitch;
        logic signed [31:0] roll;
        logic               applied;
    } t_tilt_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic        drv_valid  = 1'b0;
    t_imu_sample drv_sample = '0;
    logic        rcv_ready  = 1'b0;

    logic        apb_sel   = 1'b0;
    logic        apb_en    = 1'b0;
    logic        apb_wr    = 1'b0;
    logic [ctf_pkg::CTF_PADDR_W-1:0] apb_addr = '0;
    logic [31:0] apb_wdata = '0;
    logic [31:0] apb_rdata;
    logic        apb_ready;

    ctf_in_if  smp ();
    ctf_out_if res ();

    assign smp.valid   = drv_valid;
    assign smp.accel_x = drv_sample.ax;
    assign smp.accel_y = drv_sample.ay;
    assign smp.accel_z = drv_sample.az;
    assign smp.gyro_x  = drv_sample.gx;
    assign smp.gyro_y  = drv_sample.gy;
    assign res.ready   = rcv_ready;

    complementary_tilt_filter_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp),
        .o_res   (res),
        .psel    (apb_sel),
        .penable (apb_en),
        .pwrite  (apb_wr),
        .paddr   (apb_addr),
        .pwdata  (apb_wdata),
        .prdata  (apb_rdata),
        .pready  (apb_ready)
    );

    always #6 i_clk = ~i_clk;

    // Filter state and register copies used by the predictor.
    logic [15:0]        cfg_dt      = ctf_pkg::CTF_DT_RESET;
    logic [16:0]        cfg_weight  = ctf_pkg::CTF_WEIGHT_RESET;
    logic [16:0]        cfg_gate_lo = ctf_pkg::CTF_GATE_LO_RESET;
    logic [16:0]        cfg_gate_hi = ctf_pkg::CTF_GATE_HI_RESET;
    logic signed [31:0] pitch_q16   = '0;
    logic signed [31:0] roll_q16    = '0;

    longint atan_lut [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    t_imu_sample  imu_pending [$];
    t_tilt_result tilt_expected [$];

    int send_idle     = 0;
    int recv_idle     = 0;
    int errors        = 0;
    int samples_sent  = 0;
    int results_seen  = 0;
    int blends_seen   = 0;
    int settings_used = 0;
    int stall_cnt     = 0;

    function automatic logic signed [31:0] clamp_q16(longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic longint tilt_atan2(longint y, longint x);
        longint z;
        longint xs;
        longint ys;
        int     n;
        z = 0;
        if (x == 0 && y == 0) begin
            return 0;
        end
        if (x < 0) begin
            z = (y >= 0) ? DEG180_Q16 : -DEG180_Q16;
            x = -x;
            y = -y;
        end
        x = x * 16384;
        y = y * 16384;
        for (n = 0; n < CORDIC_N && n < 24; n++) begin
            xs = x >>> n;
            ys = y >>> n;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_lut[n];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_lut[n];
            end
        end
        return z;
    endfunction

    function automatic logic signed [31:0] blend_q16(logic signed [31:0] angle,
                                                     longint tilt, longint w);
        longint acc;
        acc = w * longint'(angle) + (64'sd65536 - w) * tilt;
        return clamp_q16(acc >>> 16);
    endfunction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Advances the filter state by one sample and returns the result beat.
    function automatic t_tilt_result filter_update(t_imu_sample s);
        longint       ax;
        longint       ay;
        longint       az;
        longint       dt;
        longint       mag;
        longint       w;
        t_tilt_result r;
        ax = longint'(s.ax);
        ay = longint'(s.ay);
        az = longint'(s.az);
        dt = longint'(cfg_dt);
        r.applied = 1'b0;
        pitch_q16 = clamp_q16(longint'(pitch_q16) + ((longint'(s.gx) * dt) >>> 4));
        roll_q16  = clamp_q16(longint'(roll_q16) - ((longint'(s.gy) * dt) >>> 4));
        mag = magnitude(ax) + magnitude(ay) + magnitude(az);
        if (mag > longint'(cfg_gate_lo) && mag < longint'(cfg_gate_hi)) begin
            w = longint'(cfg_weight);
            if (w > 64'sd65536) begin
                w = 64'sd65536;
            end
            pitch_q16 = blend_q16(pitch_q16, tilt_atan2(ay, az), w);
            roll_q16  = blend_q16(roll_q16, tilt_atan2(ax, az), w);
            r.applied = 1'b1;
        end
        r.pitch = pitch_q16;
        r.roll  = roll_q16;
        return r;
    endfunction

    function automatic t_imu_sample imu(int ax, int ay, int az, int gx, int gy);
        t_imu_sample s;
        s.ax = ax[15:0];
        s.ay = ay[15:0];
        s.az = az[15:0];
        s.gx = gx[15:0];
        s.gy = gy[15:0];
        return s;
    endfunction

    function automatic logic signed [15:0] spread(int r);
        int v;
        v = int'($urandom_range(2 * r)) - r;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] edge_value();
        logic signed [15:0] v;
        case ($urandom_range(5))
            0:       v = 16'sh8000;
            1:       v = 16'sh7fff;
            2:       v = -16'sd1;
            3:       v = 16'sd1;
            4:       v = 16'sd0;
            default: v = 16'($urandom());
        endcase
        return v;
    endfunction

    function automatic t_imu_sample random_sample(bit wide_gyro);
        t_imu_sample s;
        int          sel;
        sel = $urandom_range(99);
        if (sel < 55) begin
            s.ax = spread(3000);
            s.ay = spread(3000);
            s.az = spread(5500);
        end else if (sel < 70) begin
            s = '0;
            case ($urandom_range(3))
                0: s.az = spread(8000);
                1: s.ax = spread(8000);
                2: s.ay = spread(8000);
                default: begin
                    s.az = 16'(-int'($urandom_range(1, 6000)));
                    if ($urandom_range(1)) begin
                        s.ax = spread(3000);
                    end else begin
                        s.ay = spread(3000);
                    end
                end
            endcase
        end else if (sel < 85) begin
            s.ax = 16'($urandom());
            s.ay = 16'($urandom());
            s.az = 16'($urandom());
        end else begin
            s.ax = edge_value();
            s.ay = edge_value();
            s.az = edge_value();
        end
        sel = $urandom_range(99);
        if (sel < 60 && !wide_gyro) begin
            s.gx = spread(800);
            s.gy = spread(800);
        end else if (sel < 90) begin
            s.gx = 16'($urandom());
            s.gy = 16'($urandom());
        end else begin
            s.gx = edge_value();
            s.gy = edge_value();
        end
        return s;
    endfunction

    always @(posedge i_clk) begin : sample_driver
        logic slot_free;
        slot_free = !drv_valid || smp.ready;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && smp.ready) begin
                tilt_expected.push_back(filter_update(drv_sample));
                samples_sent++;
            end
            if (slot_free) begin
                if (imu_pending.size() > 0 && int'($urandom_range(99)) >= send_idle) begin
                    drv_sample <= imu_pending.pop_front();
                    drv_valid  <= 1'b1;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string field, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_tilt_result want;
        if (!i_rst_n) begin
            rcv_ready <= 1'b0;
        end else begin
            if (rcv_ready && res.valid) begin
                results_seen++;
                if (tilt_expected.size() == 0) begin
                    $display("%0t: unexpected result beat, pitch %0d roll %0d", $time,
                             res.pitch_out, res.roll_out);
                    errors++;
                end else begin
                    want = tilt_expected.pop_front();
                    check_field("pitch_out", want.pitch, res.pitch_out);
                    check_field("roll_out", want.roll, res.roll_out);
                    check_field("accel_applied", want.applied, res.accel_applied);
                    if (want.applied) begin
                        blends_seen++;
                    end
                end
            end
            rcv_ready <= int'($urandom_range(99)) >= recv_idle;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((drv_valid && smp.ready) || (res.valid && rcv_ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("%0t: timeout, no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic reg_write(ctf_pkg::t_ctf_reg idx, logic [31:0] val);
        logic [31:0] want;
        @(posedge i_clk);
        apb_sel   <= 1'b1;
        apb_en    <= 1'b0;
        apb_wr    <= 1'b1;
        apb_addr  <= {idx, 2'b00};
        apb_wdata <= val;
        @(posedge i_clk);
        apb_en <= 1'b1;
        @(posedge i_clk);
        apb_sel <= 1'b0;
        apb_en  <= 1'b0;
        apb_wr  <= 1'b0;
        case (idx)
            ctf_pkg::CTF_REG_DT_STEP: begin
                cfg_dt = val[15:0];
                want   = {16'd0, val[15:0]};
            end
            ctf_pkg::CTF_REG_GYRO_WEIGHT: begin
                cfg_weight = val[16:0];
                want       = {15'd0, val[16:0]};
            end
            ctf_pkg::CTF_REG_GATE_LOW: begin
                cfg_gate_lo = val[16:0];
                want        = {15'd0, val[16:0]};
            end
            ctf_pkg::CTF_REG_GATE_HIGH: begin
                cfg_gate_hi = val[16:0];
                want        = {15'd0, val[16:0]};
            end
            default: begin
                want = '0;
            end
        endcase
        @(posedge i_clk);
        if (!apb_ready || apb_rdata != want) begin
            $display("%0t: register %0d readback mismatch, expected %0d, actual %0d",
                     $time, idx, want, apb_rdata);
            errors++;
        end
    endtask

    task automatic set_config(int dt, int w, int lo, int hi);
        reg_write(ctf_pkg::CTF_REG_DT_STEP, dt);
        reg_write(ctf_pkg::CTF_REG_GYRO_WEIGHT, w);
        reg_write(ctf_pkg::CTF_REG_GATE_LOW, lo);
        reg_write(ctf_pkg::CTF_REG_GATE_HIGH, hi);
    endtask

    task automatic wait_drained();
        while (imu_pending.size() > 0 || drv_valid || tilt_expected.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(int n, int send_pct, int recv_pct, bit wide_gyro);
        send_idle = send_pct;
        recv_idle = recv_pct;
        repeat (n) imu_pending.push_back(random_sample(wide_gyro));
        wait_drained();
        settings_used++;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // Reset settings: gate edges, zero and axis-aligned tilts, extremes.
        imu_pending.push_back(imu(0, 0, 0, 0, 0));
        imu_pending.push_back(imu(0, 0, 4096, 0, 0));
        imu_pending.push_back(imu(4096, 0, 0, 16, -16));
        imu_pending.push_back(imu(0, 0, -4096, 0, 0));
        imu_pending.push_back(imu(0, -4096, 0, -16, 16));
        imu_pending.push_back(imu(-2000, 2000, -2000, 100, 100));
        imu_pending.push_back(imu(2000, -2000, -2000, -100, -100));
        imu_pending.push_back(imu(2048, 0, 0, 0, 0));
        imu_pending.push_back(imu(2049, 0, 0, 0, 0));
        imu_pending.push_back(imu(0, 0, 8192, 0, 0));
        imu_pending.push_back(imu(4000, 4191, 0, 0, 0));
        imu_pending.push_back(imu(-32768, -32768, -32768, -32768, 32767));
        imu_pending.push_back(imu(32767, 32767, 32767, 32767, -32768));
        imu_pending.push_back(imu(0, 0, 4096, -1, 1));
        imu_pending.push_back(imu(-1, -1, -4096, 0, 0));
        imu_pending.push_back(imu(0, 1, -4096, 0, 0));
        imu_pending.push_back(imu(1, -1, 4094, 32767, -32768));
        imu_pending.push_back(imu(-4096, 0, 1, -32768, 32767));
        run_phase(130, 19, 69, 1'b0);

        // Gyro only with the blend flagged, then accel tilt only.
        set_config(65535, 65536, 0, 98304);
        run_phase(150, 19, 69, 1'b0);
        set_config(0, 0, 0, 131071);
        run_phase(150, 19, 69, 1'b0);

        // Gate closed and large steps: drive both angles into saturation.
        set_config(65535, 131071, 98304, 0);
        repeat (20) imu_pending.push_back(imu(0, 0, 4096, 32767, -32768));
        repeat (40) imu_pending.push_back(imu(0, 0, 4096, -32768, 32767));
        run_phase(60, 69, 19, 1'b1);

        set_config(1, 32768, 100, 20000);
        run_phase(200, 69, 19, 1'b0);
        set_config(40000, 1, 0, 65535);
        run_phase(200, 69, 19, 1'b1);

        set_config($urandom_range(65535), $urandom_range(65536), $urandom_range(4000),
                   $urandom_range(6000, 98304));
        run_phase(200, 0, 0, 1'b0);
        set_config(ctf_pkg::CTF_DT_RESET, ctf_pkg::CTF_WEIGHT_RESET,
                   ctf_pkg::CTF_GATE_LO_RESET, ctf_pkg::CTF_GATE_HI_RESET);
        run_phase(180, 0, 0, 1'b0);

        if (tilt_expected.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, tilt_expected.size());
            errors++;
        end
        $display("Run covered %0d samples under %0d register settings.",
                 samples_sent, settings_used);
        $display("%0d result beats compared, %0d of them with accel blend, %0d errors.",
                 results_seen, blends_seen, errors);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
